[rtl/hav_pkg.sv]
// Package for the host address validator: state type, character codes, forms and helpers.
package hav_pkg;

   localparam logic [7:0] CHR_COLON  = 8'h3A;
   localparam logic [7:0] CHR_DOT    = 8'h2E;
   localparam logic [7:0] CHR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHR_ZERO   = 8'h30;

   localparam logic [1:0] FORM_INVALID = 2'd0;
   localparam logic [1:0] FORM_IPV4    = 2'd1;
   localparam logic [1:0] FORM_IPV6    = 2'd2;
   localparam logic [1:0] FORM_DNS     = 2'd3;

   localparam logic [8:0] LENGTH_MAX      = 9'd511;
   localparam logic [8:0] NAME_LENGTH_MAX = 9'd253;
   localparam logic [6:0] LABEL_MAX       = 7'd63;
   localparam logic [6:0] LABEL_SAT       = 7'd127;
   localparam logic [2:0] COUNT3_SAT      = 3'd7;
   localparam logic [2:0] HEX_DIGITS_MAX  = 3'd4;
   localparam logic [2:0] QUAD_DIGITS_MAX = 3'd3;
   localparam logic [9:0] QUAD_VALUE_MAX  = 10'd255;
   localparam logic [3:0] GROUPS_FULL     = 4'd8;
   localparam logic [3:0] QUAD_PART_COUNT = 4'd4;
   localparam logic [1:0] COLON_RUN_SAT   = 2'd3;

   typedef struct packed {
      logic [8:0] length_count;
      logic [7:0] prev_char;
      logic       colon_seen;
      logic       only_digits_dots;
      logic       quad_ok;
      logic [2:0] quad_parts;
      logic [2:0] quad_digits;
      logic [9:0] quad_value;
      logic       quad_zero_lead;
      logic       name_ok;
      logic       dot_pending;
      logic [6:0] label_count;
      logic       six_ok;
      logic       double_colon_seen;
      logic [3:0] group_count;
      logic [2:0] hex_count;
      logic       dotted_piece;
      logic [1:0] colon_run;
   } hav_state_type;

   localparam hav_state_type STATE_CLEAR = '{
      length_count: 9'd0, prev_char: 8'd0, colon_seen: 1'b0, only_digits_dots: 1'b1,
      quad_ok: 1'b1, quad_parts: 3'd0, quad_digits: 3'd0, quad_value: 10'd0,
      quad_zero_lead: 1'b0, name_ok: 1'b1, dot_pending: 1'b0, label_count: 7'd0,
      six_ok: 1'b1, double_colon_seen: 1'b0, group_count: 4'd0, hex_count: 3'd0,
      dotted_piece: 1'b0, colon_run: 2'd0};

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dig(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_dig(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // Group count add, saturating at 15.
   function automatic logic [3:0] add_groups(input logic [3:0] g, input logic [1:0] n);
      logic [4:0] sum;
      sum = {1'b0, g} + {3'd0, n};
      return sum[4] ? 4'hF : sum[3:0];
   endfunction

endpackage

[rtl/host_address_validator.sv]
// Host address validator: classifies a streamed host string as IPv4, IPv6 or DNS name.
// A word accepted into the input register is processed from there; if it is the last word
// of a string, its result is registered in the result register and offered on the rsp channel.
// Throughput: one word per cycle, set by the single character-update stage; a last word
// waits only while an earlier result is held in the result register by rsp_stall.
// Reset: synchronous and active high; it clears the string state and both stages, and
// sets allow_names to one.
module host_address_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_no_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res,
   output logic [1:0] rsp_form,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_allow_names
);

   // The configuration register is always ready; users write it only while idle, unchecked.
   logic allow_names_ff;

   // Input register: holds one word between acceptance and processing.
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_no_char_ff;
   logic       in_last_ff;

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_valid_res_ff;
   logic [1:0] rsp_form_ff;

   hav_pkg::hav_state_type state_ff;
   hav_pkg::hav_state_type state_in;
   logic [1:0]             form_in;

   logic       advance;
   logic       req_accept;
   logic [7:0] c;
   logic [3:0] fin_groups;
   logic [3:0] fin_parts;
   logic       fin_quad;
   logic       fin_ok;
   logic       ends_dot;
   logic [8:0] dlen;
   logic [9:0] digit;

   // The held word moves on unless it ends a string and the result register is
   // still occupied by a result that is not being taken.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_form      = rsp_form_ff;

   assign c     = in_char_ff;
   assign digit = {6'd0, c[3:0]};

   // Character update followed by the end-of-string judgement, on the updated state.
   always_comb begin
      state_in   = state_ff;
      form_in    = hav_pkg::FORM_INVALID;
      fin_groups = 4'd0;
      fin_parts  = 4'd0;
      fin_quad   = 1'b0;
      fin_ok     = 1'b0;
      ends_dot   = 1'b0;
      dlen       = 9'd0;

      if (!in_no_char_ff) begin
         if (!(hav_pkg::is_dig(c) || c == hav_pkg::CHR_DOT)) begin
            state_in.only_digits_dots = 1'b0;
         end

         // IPv6 piece tracking, with the dotted-quad checker restarted at each colon.
         if (c == hav_pkg::CHR_COLON) begin
            state_in.colon_seen = 1'b1;
            if (state_in.colon_run != hav_pkg::COLON_RUN_SAT) begin
               state_in.colon_run = state_in.colon_run + 2'd1;
            end
            if (state_in.colon_run == 2'd1) begin
               if (state_in.dotted_piece) begin
                  state_in.six_ok = 1'b0;
               end else if (state_in.hex_count > hav_pkg::HEX_DIGITS_MAX) begin
                  state_in.six_ok = 1'b0;
               end else if (state_in.hex_count != 3'd0) begin
                  state_in.group_count = hav_pkg::add_groups(state_in.group_count, 2'd1);
               end
            end else if (state_in.colon_run == 2'd2) begin
               if (state_in.double_colon_seen) begin
                  state_in.six_ok = 1'b0;
               end
               state_in.double_colon_seen = 1'b1;
            end else begin
               state_in.six_ok = 1'b0;
            end
            state_in.hex_count      = 3'd0;
            state_in.dotted_piece   = 1'b0;
            state_in.quad_ok        = 1'b1;
            state_in.quad_parts     = 3'd0;
            state_in.quad_digits    = 3'd0;
            state_in.quad_value     = 10'd0;
            state_in.quad_zero_lead = 1'b0;
         end else begin
            // A lone colon at the very start leaves an empty first piece.
            if (state_in.colon_run == 2'd1 && state_ff.length_count == 9'd1) begin
               state_in.six_ok = 1'b0;
            end
            state_in.colon_run = 2'd0;
            if (c == hav_pkg::CHR_DOT) begin
               state_in.dotted_piece = 1'b1;
            end else if (!hav_pkg::is_hex(c)) begin
               state_in.six_ok = 1'b0;
            end
            if (state_in.hex_count != hav_pkg::COUNT3_SAT) begin
               state_in.hex_count = state_in.hex_count + 3'd1;
            end

            // Dotted-quad part tracking.
            if (hav_pkg::is_dig(c)) begin
               if (state_in.quad_digits != 3'd0 && state_in.quad_zero_lead) begin
                  state_in.quad_ok = 1'b0;
               end
               if (state_in.quad_digits == 3'd0) begin
                  state_in.quad_zero_lead = (c == hav_pkg::CHR_ZERO);
               end
               if (state_in.quad_digits != hav_pkg::COUNT3_SAT) begin
                  state_in.quad_digits = state_in.quad_digits + 3'd1;
               end
               if (state_in.quad_digits > hav_pkg::QUAD_DIGITS_MAX) begin
                  state_in.quad_ok = 1'b0;
               end else begin
                  // The previous value is at most 99 here, so ten bits suffice.
                  state_in.quad_value = (state_in.quad_value << 3)
                                      + (state_in.quad_value << 1) + digit;
                  if (state_in.quad_value > hav_pkg::QUAD_VALUE_MAX) begin
                     state_in.quad_ok = 1'b0;
                  end
               end
            end else if (c == hav_pkg::CHR_DOT) begin
               if (state_in.quad_digits == 3'd0) begin
                  state_in.quad_ok = 1'b0;
               end else if (state_in.quad_parts != hav_pkg::COUNT3_SAT) begin
                  state_in.quad_parts = state_in.quad_parts + 3'd1;
               end
               state_in.quad_digits    = 3'd0;
               state_in.quad_value     = 10'd0;
               state_in.quad_zero_lead = 1'b0;
            end else begin
               state_in.quad_ok = 1'b0;
            end
         end

         // DNS label tracking. A dot opening an empty label is only an error if
         // anything follows it, since it may yet be the stripped trailing dot.
         if (state_in.dot_pending) begin
            state_in.name_ok = 1'b0;
         end
         state_in.dot_pending = 1'b0;
         if (c == hav_pkg::CHR_DOT) begin
            if (state_in.label_count == 7'd0) begin
               state_in.dot_pending = 1'b1;
            end else if (state_ff.prev_char == hav_pkg::CHR_HYPHEN) begin
               state_in.name_ok = 1'b0;
            end
            state_in.label_count = 7'd0;
         end else if (hav_pkg::is_alnum(c) || c == hav_pkg::CHR_HYPHEN) begin
            if (state_in.label_count == 7'd0 && c == hav_pkg::CHR_HYPHEN) begin
               state_in.name_ok = 1'b0;
            end
            if (state_in.label_count != hav_pkg::LABEL_SAT) begin
               state_in.label_count = state_in.label_count + 7'd1;
            end
            if (state_in.label_count > hav_pkg::LABEL_MAX) begin
               state_in.name_ok = 1'b0;
            end
         end else begin
            state_in.name_ok = 1'b0;
         end

         state_in.prev_char = c;
         if (state_in.length_count != hav_pkg::LENGTH_MAX) begin
            state_in.length_count = state_in.length_count + 9'd1;
         end
      end

      // Judgement of the finished string.
      fin_parts  = {1'b0, state_in.quad_parts} + {3'd0, (state_in.quad_digits != 3'd0)};
      fin_quad   = state_in.quad_ok && (fin_parts == hav_pkg::QUAD_PART_COUNT);
      fin_groups = state_in.group_count;
      ends_dot   = (state_in.prev_char == hav_pkg::CHR_DOT);
      dlen       = state_in.length_count - {8'd0, ends_dot};
      if (state_in.length_count == 9'd0) begin
         form_in = hav_pkg::FORM_INVALID;
      end else if (state_in.colon_seen) begin
         fin_ok = state_in.six_ok;
         if (state_in.dotted_piece) begin
            if (!fin_quad) begin
               fin_ok = 1'b0;
            end
            fin_groups = hav_pkg::add_groups(fin_groups, 2'd2);
         end else if (state_in.hex_count != 3'd0) begin
            if (state_in.hex_count > hav_pkg::HEX_DIGITS_MAX) begin
               fin_ok = 1'b0;
            end else begin
               fin_groups = hav_pkg::add_groups(fin_groups, 2'd1);
            end
         end else if (state_in.colon_run == 2'd1) begin
            fin_ok = 1'b0;
         end
         if (state_in.double_colon_seen) begin
            if (fin_groups >= hav_pkg::GROUPS_FULL) begin
               fin_ok = 1'b0;
            end
         end else if (fin_groups != hav_pkg::GROUPS_FULL) begin
            fin_ok = 1'b0;
         end
         form_in = fin_ok ? hav_pkg::FORM_IPV6 : hav_pkg::FORM_INVALID;
      end else if (fin_quad) begin
         form_in = hav_pkg::FORM_IPV4;
      end else if (state_in.only_digits_dots || !allow_names_ff) begin
         form_in = hav_pkg::FORM_INVALID;
      end else if (state_in.name_ok
                   && !(!ends_dot && state_in.prev_char == hav_pkg::CHR_HYPHEN)
                   && dlen != 9'd0 && dlen <= hav_pkg::NAME_LENGTH_MAX) begin
         form_in = hav_pkg::FORM_DNS;
      end

      // The state is cleared for the next string once a result is produced.
      if (in_last_ff) begin
         state_in = hav_pkg::STATE_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_names_ff <= 1'b1;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= hav_pkg::STATE_CLEAR;
      end else begin
         if (csr_valid && csr_ready) begin
            allow_names_ff <= csr_allow_names;
         end

         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            state_ff <= state_in;
         end

         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff    <= req_character;
         in_no_char_ff <= req_no_char;
         in_last_ff    <= req_last;
      end
      if (advance && in_last_ff) begin
         rsp_valid_res_ff <= (form_in != hav_pkg::FORM_INVALID);
         rsp_form_ff      <= form_in;
      end
   end

endmodule
